### sv/phcg_pkg.sv
// ---------------------------------------------------------------------------
// phcg_pkg
// Constants and helpers for the packet header checksum generator.
// ---------------------------------------------------------------------------
package phcg_pkg;

   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;
   localparam int OffsetWidth  = 24;
   localparam int CountWidth   = 25;
   localparam int SumWidth     = 20;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type RegSrcBase     = 3'd0;
   localparam csr_index_type RegSrcCount    = 3'd1;
   localparam csr_index_type RegDstAddr     = 3'd2;
   localparam csr_index_type RegTtlValue    = 3'd3;
   localparam csr_index_type RegUseUdp      = 3'd4;
   localparam csr_index_type RegTotalLength = 3'd5;
   localparam csr_index_type RegIpIdent     = 3'd6;
   localparam csr_index_type RegL4Partial   = 3'd7;

   localparam logic [31:0] SrcBaseReset     = 32'h0A00_0001;
   localparam logic [24:0] SrcCountReset    = 25'd254;
   localparam logic [7:0]  TtlValueReset    = 8'd2;
   localparam logic [15:0] TotalLengthReset = 16'd40;

   localparam logic [7:0]  ProtoTcp      = 8'd6;
   localparam logic [7:0]  ProtoUdp      = 8'd17;
   localparam logic [15:0] IpVerIhlTos   = 16'h4500;
   localparam logic [15:0] IpHeaderBytes = 16'd20;
   localparam logic [15:0] CsumAllOnes   = 16'hFFFF;

   // end-around carry fold of a sum of up to sixteen 16-bit words
   function automatic logic [15:0] fold_csum(input logic [SumWidth-1:0] s);
      logic [16:0] f1;
      logic [15:0] f2;
      f1 = {1'b0, s[15:0]} + {13'd0, s[19:16]};
      f2 = f1[15:0] + {15'd0, f1[16]};
      return f2;
   endfunction

endpackage

### sv/packet_header_checksum_generator_core.sv
// ---------------------------------------------------------------------------
// packet_header_checksum_generator_core
// Per request, yields source address, IPv4 header checksum and TCP/UDP
// checksum for one test packet, cycling the source through a range.
// ---------------------------------------------------------------------------
// One request is taken every cycle while req_stall is low. The source address
// is latched in an input register at the request transfer, and the word sums,
// carry fold and complement settle into the result register when it loads.
// Under a stalled result the input register still takes one more request
// before req_stall rises. A request with send_request low produces no result
// and leaves the source offset as it is. Registers lie at byte address
// 4*index.
module packet_header_checksum_generator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_send_request,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [31:0]                        rsp_source_address,
   output logic [15:0]                        rsp_ip_header_checksum,
   output logic [15:0]                        rsp_l4_checksum,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [phcg_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [phcg_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [phcg_pkg::CsrDataWidth-1:0]  prdata,
   output logic                               pready
);
   import phcg_pkg::*;

   logic [31:0] src_base_ff;
   logic [24:0] src_count_ff;
   logic [31:0] dst_addr_ff;
   logic [7:0]  ttl_value_ff;
   logic        use_udp_ff;
   logic [15:0] total_length_ff;
   logic [15:0] ip_ident_ff;
   logic [15:0] l4_partial_sum_ff;

   logic [OffsetWidth-1:0] offset_ff;
   logic [OffsetWidth-1:0] offset_in;
   logic [CountWidth-1:0]  offset_inc;

   logic                s1_valid_ff;
   logic [31:0]         s1_src_ff;
   logic                rsp_valid_ff;
   logic [31:0]         rsp_src_ff;
   logic [15:0]         rsp_ipck_ff;
   logic [15:0]         rsp_l4ck_ff;

   logic                s1_load, rsp_load;
   logic                req_accept;
   logic                csr_write;
   csr_index_type       csr_index;
   logic [7:0]          proto;
   logic [15:0]         l4_len;
   logic [SumWidth-1:0] ip_sum_in;
   logic [SumWidth-1:0] l4_sum_in;
   logic [15:0]         ipck_in;
   logic [15:0]         l4ck_raw;
   logic [15:0]         l4ck_in;

   // configuration port
   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_base_ff       <= SrcBaseReset;
         src_count_ff      <= SrcCountReset;
         dst_addr_ff       <= '0;
         ttl_value_ff      <= TtlValueReset;
         use_udp_ff        <= 1'b0;
         total_length_ff   <= TotalLengthReset;
         ip_ident_ff       <= '0;
         l4_partial_sum_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            RegSrcBase:     src_base_ff       <= pwdata;
            RegSrcCount:    src_count_ff      <= pwdata[24:0];
            RegDstAddr:     dst_addr_ff       <= pwdata;
            RegTtlValue:    ttl_value_ff      <= pwdata[7:0];
            RegUseUdp:      use_udp_ff        <= pwdata[0];
            RegTotalLength: total_length_ff   <= pwdata[15:0];
            RegIpIdent:     ip_ident_ff       <= pwdata[15:0];
            RegL4Partial:   l4_partial_sum_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         RegSrcBase:     prdata = src_base_ff;
         RegSrcCount:    prdata = {7'd0, src_count_ff};
         RegDstAddr:     prdata = dst_addr_ff;
         RegTtlValue:    prdata = {24'd0, ttl_value_ff};
         RegUseUdp:      prdata = {31'd0, use_udp_ff};
         RegTotalLength: prdata = {16'd0, total_length_ff};
         RegIpIdent:     prdata = {16'd0, ip_ident_ff};
         RegL4Partial:   prdata = {16'd0, l4_partial_sum_ff};
         default:        prdata = '0;
      endcase
   end

   // pipeline flow
   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || rsp_load;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && !req_stall;

   // source offset walk
   assign offset_inc = {1'b0, offset_ff} + {{(CountWidth-1){1'b0}}, 1'b1};
   assign offset_in  = (offset_inc >= src_count_ff) ? '0 : offset_inc[OffsetWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (req_accept && req_send_request) begin
         offset_ff <= offset_in;
      end
   end

   // input register: source address
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_accept && req_send_request;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_src_ff <= src_base_ff + {{(32-OffsetWidth){1'b0}}, offset_ff};
      end
   end

   // word sums, fold and complement
   assign proto  = use_udp_ff ? ProtoUdp : ProtoTcp;
   assign l4_len = total_length_ff - IpHeaderBytes;

   assign ip_sum_in = {4'd0, IpVerIhlTos} + {4'd0, total_length_ff} + {4'd0, ip_ident_ff}
                    + {4'd0, ttl_value_ff, proto}
                    + {4'd0, s1_src_ff[31:16]} + {4'd0, s1_src_ff[15:0]}
                    + {4'd0, dst_addr_ff[31:16]} + {4'd0, dst_addr_ff[15:0]};

   assign l4_sum_in = {4'd0, s1_src_ff[31:16]} + {4'd0, s1_src_ff[15:0]}
                    + {4'd0, dst_addr_ff[31:16]} + {4'd0, dst_addr_ff[15:0]}
                    + {12'd0, proto} + {4'd0, l4_len} + {4'd0, l4_partial_sum_ff};

   assign ipck_in  = ~fold_csum(ip_sum_in);
   assign l4ck_raw = ~fold_csum(l4_sum_in);
   assign l4ck_in  = (use_udp_ff && (l4ck_raw == '0)) ? CsumAllOnes : l4ck_raw;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_src_ff  <= s1_src_ff;
         rsp_ipck_ff <= ipck_in;
         rsp_l4ck_ff <= l4ck_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_source_address     = rsp_src_ff;
   assign rsp_ip_header_checksum = rsp_ipck_ff;
   assign rsp_l4_checksum        = rsp_l4ck_ff;

`ifndef SYNTHESIS
   a_req_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_send_request) |=> s1_valid_ff)
      else $error("request transfer did not reach the input register");

   a_offset_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_send_request) |=>
         ((offset_ff == '0) || (offset_ff == $past(offset_ff) + 24'd1)))
      else $error("source offset stepped wrongly");

   a_offset_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && req_send_request) |=> $stable(offset_ff))
      else $error("source offset moved without a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         (rsp_valid_ff && $stable(rsp_src_ff) && $stable(rsp_ipck_ff)
          && $stable(rsp_l4ck_ff)))
      else $error("stalled result changed");
`endif

endmodule
